// ----- src/utf8v_pkg.sv -----
package utf8v_pkg;

   // Byte ranges of strict UTF-8.
   localparam logic [7:0] ASCII_MAX      = 8'h7f;
   localparam logic [7:0] C0_MAX         = 8'h1f;
   localparam logic [7:0] DEL_CHAR       = 8'h7f;
   localparam logic [7:0] LEAD2_MIN      = 8'hc2;
   localparam logic [7:0] LEAD2_MAX      = 8'hdf;
   localparam logic [7:0] LEAD3_MIN      = 8'he0;
   localparam logic [7:0] LEAD3_MAX      = 8'hef;
   localparam logic [7:0] LEAD3_SURR     = 8'hed;
   localparam logic [7:0] LEAD4_MIN      = 8'hf0;
   localparam logic [7:0] LEAD4_MAX      = 8'hf4;
   localparam logic [7:0] CONT_MIN       = 8'h80;
   localparam logic [7:0] CONT_MAX       = 8'hbf;
   localparam logic [7:0] E0_SECOND_MIN  = 8'ha0;
   localparam logic [7:0] ED_SECOND_MAX  = 8'h9f;
   localparam logic [7:0] F0_SECOND_MIN  = 8'h90;
   localparam logic [7:0] F4_SECOND_MAX  = 8'h8f;

   // Code points rejected as C1 controls (DEL included).
   localparam logic [20:0] C1_CP_MIN     = 21'h00007f;
   localparam logic [20:0] C1_CP_MAX     = 21'h00009f;

   localparam int CP_WIDTH = 21;

   typedef struct packed {
      logic [1:0]          pending_continuations;
      logic                awaiting_second_byte;
      logic [7:0]          second_low_bound;
      logic [7:0]          second_high_bound;
      logic [CP_WIDTH-1:0] partial_code_point;
      logic                error_seen;
   } state_type;

   localparam state_type STATE_RESET = '{
      pending_continuations: 2'd0,
      awaiting_second_byte:  1'b0,
      second_low_bound:      CONT_MIN,
      second_high_bound:     CONT_MAX,
      partial_code_point:    '0,
      error_seen:            1'b0
   };

endpackage

// ----- src/utf8v_decode.sv -----
// Next-state and verdict logic for one byte of a text.
module utf8v_decode (
   input  utf8v_pkg::state_type state_cur,
   input  logic [7:0]           text_byte,
   input  logic                 reject_controls,
   input  logic                 is_last,
   output utf8v_pkg::state_type state_nxt,
   output logic                 valid_so_far
);

   utf8v_pkg::state_type s;
   logic                 bad;
   logic [utf8v_pkg::CP_WIDTH-1:0] cp;

   always_comb begin
      s   = state_cur;
      bad = 1'b0;
      cp  = {state_cur.partial_code_point[utf8v_pkg::CP_WIDTH-7:0], text_byte[5:0]};
      if (!state_cur.error_seen) begin
         if (state_cur.pending_continuations == 2'd0) begin
            if (text_byte <= utf8v_pkg::ASCII_MAX) begin
               bad = reject_controls && ((text_byte <= utf8v_pkg::C0_MAX) ||
                                         (text_byte == utf8v_pkg::DEL_CHAR));
            end else if (text_byte >= utf8v_pkg::LEAD2_MIN &&
                         text_byte <= utf8v_pkg::LEAD2_MAX) begin
               s.pending_continuations = 2'd1;
               s.awaiting_second_byte  = 1'b1;
               s.second_low_bound      = utf8v_pkg::CONT_MIN;
               s.second_high_bound     = utf8v_pkg::CONT_MAX;
               s.partial_code_point    = {16'd0, text_byte[4:0]};
            end else if (text_byte >= utf8v_pkg::LEAD3_MIN &&
                         text_byte <= utf8v_pkg::LEAD3_MAX) begin
               s.pending_continuations = 2'd2;
               s.awaiting_second_byte  = 1'b1;
               s.second_low_bound      = (text_byte == utf8v_pkg::LEAD3_MIN) ?
                                         utf8v_pkg::E0_SECOND_MIN : utf8v_pkg::CONT_MIN;
               s.second_high_bound     = (text_byte == utf8v_pkg::LEAD3_SURR) ?
                                         utf8v_pkg::ED_SECOND_MAX : utf8v_pkg::CONT_MAX;
               s.partial_code_point    = {17'd0, text_byte[3:0]};
            end else if (text_byte >= utf8v_pkg::LEAD4_MIN &&
                         text_byte <= utf8v_pkg::LEAD4_MAX) begin
               s.pending_continuations = 2'd3;
               s.awaiting_second_byte  = 1'b1;
               s.second_low_bound      = (text_byte == utf8v_pkg::LEAD4_MIN) ?
                                         utf8v_pkg::F0_SECOND_MIN : utf8v_pkg::CONT_MIN;
               s.second_high_bound     = (text_byte == utf8v_pkg::LEAD4_MAX) ?
                                         utf8v_pkg::F4_SECOND_MAX : utf8v_pkg::CONT_MAX;
               s.partial_code_point    = {18'd0, text_byte[2:0]};
            end else begin
               bad = 1'b1;
            end
         end else begin
            if (state_cur.awaiting_second_byte &&
                (text_byte < state_cur.second_low_bound ||
                 text_byte > state_cur.second_high_bound)) begin
               bad = 1'b1;
            end else if (text_byte < utf8v_pkg::CONT_MIN ||
                         text_byte > utf8v_pkg::CONT_MAX) begin
               bad = 1'b1;
            end else begin
               s.awaiting_second_byte  = 1'b0;
               s.partial_code_point    = cp;
               s.pending_continuations = state_cur.pending_continuations - 2'd1;
               if (s.pending_continuations == 2'd0) begin
                  // The sequence is complete; check the decoded code point.
                  s   = utf8v_pkg::STATE_RESET;
                  bad = reject_controls && cp >= utf8v_pkg::C1_CP_MIN &&
                        cp <= utf8v_pkg::C1_CP_MAX;
               end
            end
         end
      end
      // A text that ends inside a sequence is truncated.
      if (is_last && s.pending_continuations != 2'd0) begin
         bad = 1'b1;
      end
      if (bad) begin
         s            = utf8v_pkg::STATE_RESET;
         s.error_seen = 1'b1;
      end
      valid_so_far = !s.error_seen;
      state_nxt    = is_last ? utf8v_pkg::STATE_RESET : s;
   end

endmodule

// ----- src/utf8_stream_validator.sv -----
// Strict UTF-8 validator for a byte stream. Each item carries one byte of a
// text, a flag that asks for control characters to be rejected, and tlast on
// the final byte. Every item yields exactly one result item: tdata bit 0 is 1
// while no violation has been seen in the current text, and on the last byte
// it is the final verdict, which also fails a text that ends inside a
// multi-byte sequence. The result's tlast echoes the input's tlast, and the
// decoder state returns to its reset values after the last byte. The block
// takes one item per clock cycle; an accepted item is held in the input
// register, and its result is delivered from the result register. The state
// update between the input register and the result register lets a byte
// follow in every cycle as long as the result side keeps taking items.
module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   // Input channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] reject_controls
   input  logic       req_tlast,   // is_last
   // Result channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] valid_so_far, [7:1] zero
   output logic       rsp_tlast    // text_done
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_rc_ff,    in_rc_in;
   logic       in_last_ff,  in_last_in;

   // Decoder state, updated when an item moves to the result register.
   utf8v_pkg::state_type state_ff, state_in, state_nxt;

   // Result register.
   logic out_valid_ff, out_valid_in;
   logic out_ok_ff,    out_ok_in;
   logic out_last_ff,  out_last_in;

   logic advance;
   logic valid_so_far;

   utf8v_decode u_decode (
      .state_cur       (state_ff),
      .text_byte       (in_byte_ff),
      .reject_controls (in_rc_ff),
      .is_last         (in_last_ff),
      .state_nxt       (state_nxt),
      .valid_so_far    (valid_so_far)
   );

   // The held item moves on when the result register is empty or being
   // drained in this cycle; the input register refills in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_rc_in     = in_rc_ff;
      in_last_in   = in_last_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_last_in  = out_last_ff;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in  = 1'b0;
         state_in     = state_nxt;
         out_valid_in = 1'b1;
         out_ok_in    = valid_so_far;
         out_last_in  = in_last_ff;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_rc_in    = req_tuser;
         in_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= utf8v_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_byte_ff  <= in_byte_in;
      in_rc_ff    <= in_rc_in;
      in_last_ff  <= in_last_in;
      out_ok_ff   <= out_ok_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ok_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTH
   // Closing a text leaves the decoder in its reset state.
   a_reset_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == utf8v_pkg::STATE_RESET)
      else $error("decoder state not cleared after last item of a text");

   // A violation stays recorded until the text ends.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff && state_ff.error_seen |=> state_ff.error_seen)
      else $error("error flag dropped inside a text");

   // Once an error is recorded, the next result reports the text as invalid.
   a_error_reported: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff.error_seen |=> !rsp_tdata[0])
      else $error("result reports valid after a recorded violation");

   // A recorded violation always drops the open sequence.
   a_no_open_seq_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen |-> state_ff.pending_continuations == 2'd0)
      else $error("sequence left open after a violation");
`endif

endmodule

// ----- dv/tb_utf8_stream_validator.sv -----
module tb_utf8_stream_validator;

   // Clock and the single reset pulse at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Stimulus side. Every input is given a known value from time zero.
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] text_byte
   logic       req_tuser  = 1'b0;   // [0] reject_controls
   logic       req_tlast  = 1'b0;   // is_last

   // Result side.
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] valid_so_far, [7:1] zero
   logic       rsp_tlast;           // text_done

   utf8_stream_validator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One byte of a text as the driver presents it.
   typedef struct {
      logic [7:0] text_byte;
      logic       reject_controls;
      logic       is_last;
   } text_item_type;

   // One expected result: the running verdict and the end-of-text marker.
   typedef struct {
      logic valid_so_far;
      logic text_done;
   } verdict_type;

   text_item_type byte_queue[$];      // bytes waiting to be offered
   verdict_type   verdict_queue[$];   // verdicts waiting for their result item

   // The testbench's own copy of the decoder state.
   utf8v_pkg::state_type decoder = utf8v_pkg::STATE_RESET;

   int  mismatch_count  = 0;
   int  results_seen    = 0;
   int  cycle_count     = 0;
   bit  req_taken       = 1'b0;   // an item was accepted at the last rising edge
   int  send_idle_left  = 0;
   int  recv_stall_left = 0;
   bit  long_hold_done  = 1'b0;

   // ------------------------------------------------------------------
   // Predictor. A violation drops any open sequence and makes the text
   // fail until its last byte; the last byte returns everything to reset.
   // ------------------------------------------------------------------
   function automatic void mark_violation();
      decoder            = utf8v_pkg::STATE_RESET;
      decoder.error_seen = 1'b1;
   endfunction

   function automatic void start_sequence(input logic [1:0] count, input logic [20:0] bits,
                                          input logic [7:0] low_bound,
                                          input logic [7:0] high_bound);
      decoder.pending_continuations = count;
      decoder.awaiting_second_byte  = 1'b1;
      decoder.second_low_bound      = low_bound;
      decoder.second_high_bound     = high_bound;
      decoder.partial_code_point    = bits;
   endfunction

   function automatic logic check_byte(input logic [7:0] b, input logic reject_controls,
                                       input logic is_last);
      logic [20:0] code_point;
      logic        verdict;
      if (!decoder.error_seen) begin
         if (decoder.pending_continuations == 2'd0) begin
            // The byte is read as a lead.
            if (b <= utf8v_pkg::ASCII_MAX) begin
               if (reject_controls && (b <= utf8v_pkg::C0_MAX || b == utf8v_pkg::DEL_CHAR))
                  mark_violation();
            end else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX) begin
               start_sequence(2'd1, {16'd0, b[4:0]}, utf8v_pkg::CONT_MIN,
                              utf8v_pkg::CONT_MAX);
            end else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX) begin
               start_sequence(2'd2, {17'd0, b[3:0]},
                              (b == utf8v_pkg::LEAD3_MIN) ?
                              utf8v_pkg::E0_SECOND_MIN : utf8v_pkg::CONT_MIN,
                              (b == utf8v_pkg::LEAD3_SURR) ?
                              utf8v_pkg::ED_SECOND_MAX : utf8v_pkg::CONT_MAX);
            end else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX) begin
               start_sequence(2'd3, {18'd0, b[2:0]},
                              (b == utf8v_pkg::LEAD4_MIN) ?
                              utf8v_pkg::F0_SECOND_MIN : utf8v_pkg::CONT_MIN,
                              (b == utf8v_pkg::LEAD4_MAX) ?
                              utf8v_pkg::F4_SECOND_MAX : utf8v_pkg::CONT_MAX);
            end else begin
               mark_violation();
            end
         end else if ((decoder.awaiting_second_byte &&
                       (b < decoder.second_low_bound || b > decoder.second_high_bound)) ||
                      b < utf8v_pkg::CONT_MIN || b > utf8v_pkg::CONT_MAX) begin
            mark_violation();
         end else begin
            code_point = {decoder.partial_code_point[14:0], b[5:0]};
            decoder.awaiting_second_byte  = 1'b0;
            decoder.partial_code_point    = code_point;
            decoder.pending_continuations = decoder.pending_continuations - 2'd1;
            if (decoder.pending_continuations == 2'd0) begin
               // The code point is complete; it is checked with this byte's flag.
               decoder = utf8v_pkg::STATE_RESET;
               if (reject_controls && code_point >= utf8v_pkg::C1_CP_MIN &&
                   code_point <= utf8v_pkg::C1_CP_MAX)
                  mark_violation();
            end
         end
      end
      // A text that stops inside a sequence is invalid.
      if (is_last && decoder.pending_continuations != 2'd0)
         mark_violation();
      verdict = !decoder.error_seen;
      if (is_last)
         decoder = utf8v_pkg::STATE_RESET;
      return verdict;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b, input logic reject_controls,
                                    input logic is_last);
      text_item_type entry;
      entry.text_byte       = b;
      entry.reject_controls = reject_controls;
      entry.is_last         = is_last;
      byte_queue.insert(byte_queue.size(), entry);
   endfunction

   // Idle length: mostly none or short, now and then a long one.
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   // Builds one text and queues it; returns the number of bytes queued.
   // Most texts are well-formed code points with random content. Some are
   // damaged by a replaced, inserted or dropped byte, and a few are noise.
   function automatic int add_text();
      logic [7:0]  seq[$];
      logic [20:0] code_point;
      logic        reject_controls;
      int          n_points;
      int          pick;
      int          idx;
      reject_controls = 1'($urandom_range(0, 1));
      n_points        = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
         repeat (n_points) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end else begin
         repeat (n_points) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               code_point = 21'($urandom_range(0, 'h7f));
               seq.insert(seq.size(), code_point[7:0]);
            end else if (pick < 55) begin
               // The C1 control range gets extra weight.
               if ($urandom_range(0, 3) == 0)
                  code_point = 21'($urandom_range('h80, 'h9f));
               else
                  code_point = 21'($urandom_range('h80, 'h7ff));
               seq.insert(seq.size(), {3'b110, code_point[10:6]});
               seq.insert(seq.size(), {2'b10, code_point[5:0]});
            end else if (pick < 80) begin
               // Surrogates fall in here now and then and must be rejected.
               code_point = 21'($urandom_range('h800, 'hffff));
               seq.insert(seq.size(), {4'b1110, code_point[15:12]});
               seq.insert(seq.size(), {2'b10, code_point[11:6]});
               seq.insert(seq.size(), {2'b10, code_point[5:0]});
            end else begin
               code_point = 21'($urandom_range('h10000, 'h10ffff));
               seq.insert(seq.size(), {5'b11110, code_point[20:18]});
               seq.insert(seq.size(), {2'b10, code_point[17:12]});
               seq.insert(seq.size(), {2'b10, code_point[11:6]});
               seq.insert(seq.size(), {2'b10, code_point[5:0]});
            end
         end
         if ($urandom_range(0, 99) < 18) begin
            idx = $urandom_range(0, seq.size() - 1);
            case ($urandom_range(0, 2))
               0: seq[idx] = 8'($urandom_range(0, 255));
               1: seq.insert(idx, 8'($urandom_range(0, 255)));
               default: begin
                  void'(seq.pop_back());
                  if (seq.size() == 0)
                     seq.insert(seq.size(), 8'($urandom_range(0, 255)));
               end
            endcase
         end
      end
      foreach (seq[i]) begin
         // The control flag is normally held for the whole text, but now and
         // then it flips in the middle of one.
         if ($urandom_range(0, 99) < 3)
            reject_controls = !reject_controls;
         add_byte(seq[i], reject_controls, i == seq.size() - 1);
      end
      return seq.size();
   endfunction

   // ------------------------------------------------------------------
   // Driver. Inputs change only at the falling edge. A new item is put up
   // once the current one has been taken or the channel is idle.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_idle_left > 0) begin
            req_tvalid <= 1'b0;
            send_idle_left--;
         end else if (byte_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= byte_queue[0].text_byte;
            req_tuser  <= byte_queue[0].reject_controls;
            req_tlast  <= byte_queue[0].is_last;
            void'(byte_queue.pop_front());
            // Some windows run back to back with no idling at all.
            send_idle_left = (cycle_count[8:7] == 2'd1) ? 0 : draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure, also driven at the falling edge. Once during
   // the run it holds off for a long stretch while the sender keeps going,
   // so the block fills up and stalls its input.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!long_hold_done && results_seen >= 400) begin
         long_hold_done  = 1'b1;
         recv_stall_left = 150;
      end
      if (recv_stall_left > 0) begin
         rsp_tready <= 1'b0;
         recv_stall_left--;
      end else if (cycle_count[7:6] == 2'd0) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 20) begin
         rsp_tready <= 1'b0;
         recv_stall_left = draw_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Both handshakes are sampled at the rising edge. An accepted
   // input is predicted at once; an accepted result is compared with the
   // oldest verdict still waiting.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type predicted;
      verdict_type wanted;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken              = 1'b1;
            predicted.valid_so_far = check_byte(req_tdata, req_tuser, req_tlast);
            predicted.text_done    = req_tlast;
            verdict_queue.insert(verdict_queue.size(), predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (verdict_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result item: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
            end else begin
               wanted = verdict_queue.pop_front();
               if (rsp_tdata !== {7'd0, wanted.valid_so_far} ||
                   rsp_tlast !== wanted.text_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d mismatch: valid_so_far exp %b got %b, %s %h, %s %b %b",
                              results_seen, wanted.valid_so_far, rsp_tdata[0],
                              "tdata", rsp_tdata, "text_done exp/got", wanted.text_done,
                              rsp_tlast);
               end
            end
         end
      end
   end

   // Waits until every queued byte has been taken and every verdict checked.
   task automatic wait_drained();
      while (byte_queue.size() != 0 || req_tvalid || verdict_queue.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      int queued;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts: byte extremes, bad leads, narrowed second bytes,
      // truncation, sticky errors and a flag change inside a text.
      add_byte(8'h41, 1'b0, 1'b1);
      add_byte(8'h00, 1'b1, 1'b1);                 // control rejected
      add_byte(8'h7f, 1'b1, 1'b1);                 // DEL rejected
      add_byte(8'hff, 1'b0, 1'b1);                 // bad lead
      add_byte(8'h80, 1'b0, 1'b1);                 // stray continuation as lead
      add_byte(8'hc1, 1'b0, 1'b1);                 // overlong lead
      add_byte(8'hc2, 1'b0, 1'b0);                 // U+0080, flag set only on
      add_byte(8'h80, 1'b1, 1'b1);                 // the final byte
      add_byte(8'he0, 1'b0, 1'b0);                 // second byte below A0
      add_byte(8'h9f, 1'b0, 1'b1);
      add_byte(8'hed, 1'b1, 1'b0);                 // top of the ED range
      add_byte(8'h9f, 1'b1, 1'b0);
      add_byte(8'hbf, 1'b1, 1'b1);
      add_byte(8'hf0, 1'b0, 1'b0);                 // second byte below 90
      add_byte(8'h8f, 1'b0, 1'b1);
      add_byte(8'hf4, 1'b0, 1'b0);                 // U+10FFFF
      add_byte(8'h8f, 1'b0, 1'b0);
      add_byte(8'hbf, 1'b0, 1'b0);
      add_byte(8'hbf, 1'b0, 1'b1);
      add_byte(8'he2, 1'b0, 1'b0);                 // ends inside a sequence
      add_byte(8'h82, 1'b0, 1'b1);
      add_byte(8'hf5, 1'b0, 1'b0);                 // error stays until the end
      add_byte(8'h41, 1'b0, 1'b0);
      add_byte(8'h41, 1'b0, 1'b1);
      wait_drained();

      // First random part. The sender then pauses until every result is in.
      queued = 0;
      while (queued < 800)
         queued += add_text();
      wait_drained();

      // Second random part.
      queued = 0;
      while (queued < 800)
         queued += add_text();
      wait_drained();

      // Keep the clock running so that a stray result would be caught.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("utf8_stream_validator verification clean");
      end else begin
         $display("utf8_stream_validator verification failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #10000000;
      $display("utf8_stream_validator verification failed");
      $finish;
   end

endmodule
